// ----- hw/rtl/bcle_pkg.sv -----
// Shared types and constants for the bounded circular list engine.
`default_nettype none

package bcle_pkg;

   localparam int CAPACITY   = 32;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_W      = $clog2(CAPACITY);
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int KIND_W     = 3;
   localparam int VALUE_W    = 32;
   localparam int ITEM_W     = 32;
   localparam int STATUS_W   = 2;
   localparam int RSP_DATA_W = ((ITEM_W + STATUS_W + 7) / 8) * 8;

   typedef enum logic [KIND_W-1:0] {
      KIND_CREATE    = 3'd0,
      KIND_INS_FRONT = 3'd1,
      KIND_INS_BACK  = 3'd2,
      KIND_DEL_FRONT = 3'd3,
      KIND_DEL_BACK  = 3'd4,
      KIND_DEL_AFTER = 3'd5,
      KIND_CLEAR     = 3'd6,
      KIND_READ      = 3'd7
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_EMPTY    = 2'd1,
      STATUS_NOTFOUND = 2'd2,
      STATUS_FULL     = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ADDR_ZERO,
      ADDR_FRONT,
      ADDR_FRONT_PREV,
      ADDR_BACK,
      ADDR_LAST,
      ADDR_POS,
      ADDR_POS_NEXT
   } addr_sel_type;

   typedef enum logic [1:0] {
      FRONT_KEEP,
      FRONT_ZERO,
      FRONT_INC,
      FRONT_DEC
   } front_op_type;

   typedef enum logic [2:0] {
      CNT_KEEP,
      CNT_ONE,
      CNT_INC,
      CNT_DEC,
      CNT_ZERO
   } count_op_type;

   typedef enum logic [1:0] {
      POS_KEEP,
      POS_ZERO,
      POS_INC
   } pos_op_type;

   typedef enum logic {
      WSRC_VALUE,
      WSRC_RDATA
   } wr_src_type;

   typedef enum logic {
      ISEL_REMOVED,
      ISEL_RDATA
   } item_sel_type;

   typedef struct packed {
      logic         capture;
      logic         rd_en;
      logic         wr_en;
      addr_sel_type addr_sel;
      wr_src_type   wr_src;
      front_op_type front_op;
      count_op_type count_op;
      pos_op_type   pos_op;
      logic         clr_removed;
      logic         cap_removed;
      logic         emit;
      item_sel_type item_sel;
      status_type   status;
      logic         last;
   } ctrl_cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     empty;
      logic     full;
      logic     match;
      logic     pos_last;
      logic     out_free;
   } dp_sts_type;

endpackage

`default_nettype wire

// ----- hw/rtl/bounded_circular_list_engine_core.sv -----
// Top level of the bounded circular list engine: controller plus datapath.
// After acceptance a simple command is decoded and its word loads into the result register;
// the controller returns to accept the next command in the cycle after that word loads.
// Delete after walks the list element by element, then moves each later element
// one place toward the front with a store read followed by a store write.
// Read out gives each word from its own registered store read, issued once the prior word is out.
// Reset clears the list to empty with front at zero; the store is not cleared.
`default_nettype none

module bounded_circular_list_engine_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [bcle_pkg::VALUE_W-1:0]         req_tdata,   // value
   input  wire logic [bcle_pkg::KIND_W-1:0]          req_tuser,   // kind
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic      [bcle_pkg::RSP_DATA_W-1:0]      rsp_tdata,   // item, status, zero pad
   output logic                                      rsp_tlast
);

   import bcle_pkg::*;

   ctrl_cmd_type            cmd;
   dp_sts_type              sts;
   logic [ITEM_W-1:0]       rsp_item;
   logic [STATUS_W-1:0]     rsp_status;

   bcle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   bcle_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_kind   (req_tuser),
      .req_value  (req_tdata),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_item   (rsp_item),
      .rsp_status (rsp_status),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = RSP_DATA_W'({rsp_status, rsp_item});

endmodule

`default_nettype wire

// ----- hw/rtl/bcle_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bcle_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/bcle_dp.sv -----
// Datapath: ring pointers, element store, compare and the result register.
`default_nettype none

module bcle_dp (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire bcle_pkg::ctrl_cmd_type             cmd,
   output bcle_pkg::dp_sts_type                    sts,
   input  wire logic [bcle_pkg::KIND_W-1:0]        req_kind,
   input  wire logic [bcle_pkg::VALUE_W-1:0]       req_value,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic      [bcle_pkg::ITEM_W-1:0]        rsp_item,
   output logic      [bcle_pkg::STATUS_W-1:0]      rsp_status,
   output logic                                    rsp_last
);

   import bcle_pkg::*;

   localparam int SUM_W = CNT_W + 1;

   function automatic logic [DATA_WIDTH-1:0] word_of(logic [VALUE_W-1:0] v);
      logic signed [63:0] x;
      x = 64'(signed'(v));
      return x[DATA_WIDTH-1:0];
   endfunction

   function automatic logic [ITEM_W-1:0] item_of(logic [DATA_WIDTH-1:0] w);
      logic signed [63:0] x;
      x = 64'(signed'(w));
      return x[ITEM_W-1:0];
   endfunction

   logic [IDX_W-1:0]      front_ff, front_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      pos_ff, pos_in;
   kind_type              kind_ff;
   logic [DATA_WIDTH-1:0] value_ff;
   logic [DATA_WIDTH-1:0] removed_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ITEM_W-1:0]     rsp_item_ff;
   status_type            rsp_status_ff;
   logic                  rsp_last_ff;

   logic [CNT_W-1:0]      offset;
   logic [SUM_W-1:0]      slot_sum;
   logic [IDX_W-1:0]      slot_idx;
   logic [IDX_W-1:0]      front_prev;
   logic [IDX_W-1:0]      front_next;
   logic [IDX_W-1:0]      addr;
   logic [DATA_WIDTH-1:0] wr_data;
   logic [DATA_WIDTH-1:0] rd_data;
   logic [SUM_W-1:0]      pos_plus;

   assign front_prev = (front_ff == '0) ? IDX_W'(CAPACITY - 1) : front_ff - 1'b1;
   assign front_next = (front_ff == IDX_W'(CAPACITY - 1)) ? '0 : front_ff + 1'b1;

   // Ring position of a list offset: front plus offset, wrapped once.
   always_comb begin
      case (cmd.addr_sel)
         ADDR_BACK:     offset = count_ff;
         ADDR_LAST:     offset = count_ff - 1'b1;
         ADDR_POS:      offset = pos_ff;
         ADDR_POS_NEXT: offset = pos_ff + 1'b1;
         default:       offset = '0;
      endcase
      slot_sum = SUM_W'(front_ff) + SUM_W'(offset);
      if (slot_sum >= SUM_W'(CAPACITY)) begin
         slot_sum = slot_sum - SUM_W'(CAPACITY);
      end
      slot_idx = slot_sum[IDX_W-1:0];
   end

   always_comb begin
      unique case (cmd.addr_sel)
         ADDR_ZERO:       addr = '0;
         ADDR_FRONT_PREV: addr = front_prev;
         default:         addr = slot_idx;
      endcase
   end

   assign wr_data = (cmd.wr_src == WSRC_RDATA) ? rd_data : value_ff;

   bcle_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (addr),
      .rd_data (rd_data)
   );

   always_comb begin
      case (cmd.front_op)
         FRONT_ZERO: front_in = '0;
         FRONT_INC:  front_in = front_next;
         FRONT_DEC:  front_in = front_prev;
         default:    front_in = front_ff;
      endcase
      case (cmd.count_op)
         CNT_ONE:  count_in = CNT_W'(1);
         CNT_INC:  count_in = count_ff + 1'b1;
         CNT_DEC:  count_in = count_ff - 1'b1;
         CNT_ZERO: count_in = '0;
         default:  count_in = count_ff;
      endcase
      case (cmd.pos_op)
         POS_ZERO: pos_in = '0;
         POS_INC:  pos_in = pos_ff + 1'b1;
         default:  pos_in = pos_ff;
      endcase
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         count_ff     <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff  <= kind_type'(req_kind);
         value_ff <= word_of(req_value);
      end
      if (cmd.clr_removed) begin
         removed_ff <= '0;
      end else if (cmd.cap_removed) begin
         removed_ff <= rd_data;
      end
      if (cmd.emit) begin
         rsp_item_ff   <= (cmd.item_sel == ISEL_RDATA) ? item_of(rd_data)
                                                       : item_of(removed_ff);
         rsp_status_ff <= cmd.status;
         rsp_last_ff   <= cmd.last;
      end
   end

   assign pos_plus = SUM_W'(pos_ff) + 1'b1;

   assign sts.kind     = kind_ff;
   assign sts.empty    = (count_ff == '0);
   assign sts.full     = (count_ff == CNT_W'(CAPACITY));
   assign sts.match    = (rd_data == value_ff);
   assign sts.pos_last = (pos_plus >= SUM_W'(count_ff));
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_item   = rsp_item_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/bcle_ctrl.sv -----
// Controller state machine that sequences each command over the datapath.
`default_nettype none

module bcle_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire bcle_pkg::dp_sts_type    sts,
   output bcle_pkg::ctrl_cmd_type       cmd
);

   import bcle_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SEARCH,
      ST_CAPTURE,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_EMIT,
      ST_OUT_RD,
      ST_OUT_EMIT
   } state_type;

   state_type  state_ff, state_in;
   status_type stat_ff, stat_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      stat_in   = stat_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.clr_removed = 1'b1;
            stat_in         = STATUS_OK;
            state_in        = ST_EMIT;
            unique case (sts.kind)
               KIND_CREATE: begin
                  cmd.wr_en    = 1'b1;
                  cmd.addr_sel = ADDR_ZERO;
                  cmd.front_op = FRONT_ZERO;
                  cmd.count_op = CNT_ONE;
               end
               KIND_INS_FRONT: begin
                  if (sts.full) begin
                     stat_in = STATUS_FULL;
                  end else begin
                     cmd.wr_en    = 1'b1;
                     cmd.addr_sel = ADDR_FRONT_PREV;
                     cmd.front_op = FRONT_DEC;
                     cmd.count_op = CNT_INC;
                  end
               end
               KIND_INS_BACK: begin
                  if (sts.full) begin
                     stat_in = STATUS_FULL;
                  end else begin
                     cmd.wr_en    = 1'b1;
                     cmd.addr_sel = ADDR_BACK;
                     cmd.count_op = CNT_INC;
                  end
               end
               KIND_DEL_FRONT: begin
                  if (sts.empty) begin
                     stat_in = STATUS_EMPTY;
                  end else begin
                     cmd.rd_en    = 1'b1;
                     cmd.addr_sel = ADDR_FRONT;
                     cmd.front_op = FRONT_INC;
                     cmd.count_op = CNT_DEC;
                     state_in     = ST_CAPTURE;
                  end
               end
               KIND_DEL_BACK: begin
                  if (sts.empty) begin
                     stat_in = STATUS_EMPTY;
                  end else begin
                     cmd.rd_en    = 1'b1;
                     cmd.addr_sel = ADDR_LAST;
                     cmd.count_op = CNT_DEC;
                     state_in     = ST_CAPTURE;
                  end
               end
               KIND_DEL_AFTER: begin
                  if (sts.empty) begin
                     stat_in = STATUS_EMPTY;
                  end else begin
                     cmd.rd_en    = 1'b1;
                     cmd.addr_sel = ADDR_FRONT;
                     cmd.pos_op   = POS_ZERO;
                     state_in     = ST_SEARCH;
                  end
               end
               KIND_CLEAR: begin
                  cmd.count_op = CNT_ZERO;
               end
               KIND_READ: begin
                  if (sts.empty) begin
                     stat_in = STATUS_EMPTY;
                  end else begin
                     cmd.pos_op = POS_ZERO;
                     state_in   = ST_OUT_RD;
                  end
               end
               default: begin
                  stat_in = STATUS_OK;
               end
            endcase
         end
         // The read data holds the element at pos; the next read is issued
         // in the same cycle, so the walk does not pause between elements.
         ST_SEARCH: begin
            if (sts.pos_last) begin
               stat_in  = STATUS_NOTFOUND;
               state_in = ST_EMIT;
            end else begin
               cmd.rd_en    = 1'b1;
               cmd.addr_sel = ADDR_POS_NEXT;
               cmd.pos_op   = POS_INC;
               if (sts.match) begin
                  state_in = ST_CAPTURE;
               end
            end
         end
         ST_CAPTURE: begin
            cmd.cap_removed = 1'b1;
            state_in = (sts.kind == KIND_DEL_AFTER) ? ST_SHIFT_RD : ST_EMIT;
         end
         // Close the gap: each later element moves one place toward the front.
         ST_SHIFT_RD: begin
            if (sts.pos_last) begin
               cmd.count_op = CNT_DEC;
               state_in     = ST_EMIT;
            end else begin
               cmd.rd_en    = 1'b1;
               cmd.addr_sel = ADDR_POS_NEXT;
               state_in     = ST_SHIFT_WR;
            end
         end
         ST_SHIFT_WR: begin
            cmd.wr_en    = 1'b1;
            cmd.wr_src   = WSRC_RDATA;
            cmd.addr_sel = ADDR_POS;
            cmd.pos_op   = POS_INC;
            state_in     = ST_SHIFT_RD;
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit     = 1'b1;
               cmd.item_sel = ISEL_REMOVED;
               cmd.status   = stat_ff;
               cmd.last     = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_OUT_RD: begin
            cmd.rd_en    = 1'b1;
            cmd.addr_sel = ADDR_POS;
            state_in     = ST_OUT_EMIT;
         end
         ST_OUT_EMIT: begin
            if (sts.out_free) begin
               cmd.emit     = 1'b1;
               cmd.item_sel = ISEL_RDATA;
               cmd.status   = STATUS_OK;
               cmd.last     = sts.pos_last;
               if (sts.pos_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.pos_op = POS_INC;
                  state_in   = ST_OUT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         stat_ff  <= STATUS_OK;
      end else begin
         state_ff <= state_in;
         stat_ff  <= stat_in;
      end
   end

endmodule

`default_nettype wire
